// ===== hw/rtl/tspq_pkg.sv =====
// Shared types, codes and field widths for the three-class stable priority queue.
// No dependencies.
`timescale 1ns / 1ps

package tspq_pkg;

    localparam int DEF_CLASS_DEPTH = 16;
    localparam int NUM_CLASSES     = 3;

    localparam int CODE_W   = 8;
    localparam int NUMBER_W = 16;
    localparam int DUR_W    = 16;
    localparam int STATUS_W = 2;
    localparam int WORD_W   = NUMBER_W + DUR_W;
    localparam int CLS_W    = 2;

    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 48;
    localparam int M_TUSER_W = 3;

    // ASCII class letters
    localparam logic [CODE_W-1:0] CODE_P = 8'h50;
    localparam logic [CODE_W-1:0] CODE_G = 8'h47;
    localparam logic [CODE_W-1:0] CODE_S = 8'h53;

    localparam logic [CLS_W-1:0] CLS_HIGH = 2'd0;
    localparam logic [CLS_W-1:0] CLS_MID  = 2'd1;
    localparam logic [CLS_W-1:0] CLS_LOW  = 2'd2;

    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_POP  = 1'b1;

    localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY   = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_UNKNOWN = 2'd3;

    typedef struct packed {
        logic accept;   // input transaction taken this cycle
    } tspq_cmd_t;

    function automatic logic [CODE_W-1:0] class_letter(input logic [CLS_W-1:0] idx);
        logic [CODE_W-1:0] letter;
        case (idx)
            CLS_HIGH: letter = CODE_P;
            CLS_MID:  letter = CODE_G;
            default:  letter = CODE_S;
        endcase
        return letter;
    endfunction

endpackage

// ===== hw/rtl/tspq_ctrl.sv =====
// Handshake controller for the priority queue: one item in flight at a time.
// Depends on tspq_pkg.
`timescale 1ns / 1ps

module tspq_ctrl
    import tspq_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  logic      m_tready,
    output tspq_cmd_t cmd
);

    localparam logic STATE_IDLE = 1'b0;
    localparam logic STATE_RESP = 1'b1;

    logic state_reg;
    logic state_next;

    assign s_tready   = (state_reg == STATE_IDLE);
    assign m_tvalid   = (state_reg == STATE_RESP);
    assign cmd.accept = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            STATE_IDLE: begin
                if (s_tvalid) state_next = STATE_RESP;
            end
            STATE_RESP: begin
                if (m_tready) state_next = STATE_IDLE;
            end
            default: state_next = STATE_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= STATE_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hw/rtl/tspq_dp.sv =====
// Datapath: per-class ring pointers and counts, shared entry memory, result registers.
// Depends on tspq_pkg.
`timescale 1ns / 1ps

module tspq_dp
    import tspq_pkg::*;
#(
    parameter int CLASS_DEPTH = DEF_CLASS_DEPTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  tspq_cmd_t            cmd,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [S_TUSER_W-1:0] s_tuser,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic [M_TUSER_W-1:0] m_tuser
);

    localparam int PTR_W = (CLASS_DEPTH > 1) ? $clog2(CLASS_DEPTH) : 1;
    localparam int CNT_W = $clog2(CLASS_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(CLASS_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CLASS_DEPTH);

    logic [PTR_W-1:0] head_reg [NUM_CLASSES];
    logic [PTR_W-1:0] tail_reg [NUM_CLASSES];
    logic [CNT_W-1:0] cnt_reg  [NUM_CLASSES];

    logic [WORD_W-1:0] ring_mem [NUM_CLASSES][CLASS_DEPTH];
    logic [WORD_W-1:0] rd_q_reg;

    logic [STATUS_W-1:0] status_reg, status_next;
    logic                valid_reg, valid_next;
    logic [CLS_W-1:0]    cls_reg, cls_next;

    logic                mode;
    logic [CODE_W-1:0]   class_code;
    logic [NUMBER_W-1:0] cust_number;
    logic [DUR_W-1:0]    duration;

    logic             push_known;
    logic [CLS_W-1:0] push_cls;
    logic             pop_any;
    logic [CLS_W-1:0] pop_cls;
    logic             wr_en, rd_en;
    logic [PTR_W-1:0] wr_ptr, rd_ptr;
    logic             push_full;
    logic             now_empty;

    assign mode        = s_tuser[0];
    assign class_code  = s_tdata[7:0];
    assign cust_number = s_tdata[23:8];
    assign duration    = s_tdata[39:24];

    // class decode for push
    always_comb begin
        push_known = 1'b1;
        push_cls   = CLS_LOW;
        unique case (class_code)
            CODE_P:  push_cls = CLS_HIGH;
            CODE_G:  push_cls = CLS_MID;
            CODE_S:  push_cls = CLS_LOW;
            default: push_known = 1'b0;
        endcase
    end

    // fixed priority pick for pop
    always_comb begin
        pop_any = 1'b1;
        pop_cls = CLS_LOW;
        if (cnt_reg[0] != '0)      pop_cls = CLS_HIGH;
        else if (cnt_reg[1] != '0) pop_cls = CLS_MID;
        else if (cnt_reg[2] != '0) pop_cls = CLS_LOW;
        else                       pop_any = 1'b0;
    end

    always_comb begin
        case (push_cls)
            CLS_HIGH: begin
                wr_ptr    = tail_reg[0];
                push_full = (cnt_reg[0] == CNT_FULL);
            end
            CLS_MID: begin
                wr_ptr    = tail_reg[1];
                push_full = (cnt_reg[1] == CNT_FULL);
            end
            default: begin
                wr_ptr    = tail_reg[2];
                push_full = (cnt_reg[2] == CNT_FULL);
            end
        endcase
        case (pop_cls)
            CLS_HIGH: rd_ptr = head_reg[0];
            CLS_MID:  rd_ptr = head_reg[1];
            default:  rd_ptr = head_reg[2];
        endcase
    end

    always_comb begin
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        status_next = STAT_OK;
        valid_next  = 1'b0;
        cls_next    = pop_cls;
        if (mode == MODE_PUSH) begin
            if (!push_known)    status_next = STAT_UNKNOWN;
            else if (push_full) status_next = STAT_FULL;
            else                wr_en = cmd.accept;
        end else begin
            if (!pop_any) begin
                status_next = STAT_EMPTY;
            end else begin
                rd_en      = cmd.accept;
                valid_next = 1'b1;
            end
        end
    end

    // entry memory: number in the upper half, duration in the lower
    always_ff @(posedge aclk) begin
        if (wr_en) ring_mem[push_cls][wr_ptr] <= {cust_number, duration};
        if (rd_en) rd_q_reg <= ring_mem[pop_cls][rd_ptr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < NUM_CLASSES; c++) begin
                head_reg[c] <= '0;
                tail_reg[c] <= '0;
                cnt_reg[c]  <= '0;
            end
        end else begin
            for (int c = 0; c < NUM_CLASSES; c++) begin
                if (wr_en && (push_cls == CLS_W'(c))) begin
                    tail_reg[c] <= (tail_reg[c] == PTR_LAST) ? '0 : tail_reg[c] + 1'b1;
                    cnt_reg[c]  <= cnt_reg[c] + 1'b1;
                end
                if (rd_en && (pop_cls == CLS_W'(c))) begin
                    head_reg[c] <= (head_reg[c] == PTR_LAST) ? '0 : head_reg[c] + 1'b1;
                    cnt_reg[c]  <= cnt_reg[c] - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            status_reg <= status_next;
            valid_reg  <= valid_next;
            cls_reg    <= cls_next;
        end
    end

    // counts hold still while the result waits
    assign now_empty = (cnt_reg[0] == '0) && (cnt_reg[1] == '0) && (cnt_reg[2] == '0);

    assign m_tuser = {valid_reg, status_reg};
    assign m_tdata = {7'b0,
                      now_empty,
                      valid_reg ? rd_q_reg[DUR_W-1:0]      : {DUR_W{1'b0}},
                      valid_reg ? rd_q_reg[WORD_W-1:DUR_W] : {NUMBER_W{1'b0}},
                      valid_reg ? class_letter(cls_reg)    : {CODE_W{1'b0}}};

endmodule

// ===== hw/rtl/three_level_stable_priority_queue_top.sv =====
// Three-class stable priority queue ('P' > 'G' > 'S', FIFO within a class).
// The result transaction is offered in the cycle after the input is accepted.
// The controller holds one item until its result is taken, so no new input is
// accepted while a result is pending; a pop reads the registered-output entry memory.
// Reset: synchronous active-low aresetn empties all classes; memory is not cleared.
// Depends on tspq_pkg, tspq_ctrl, tspq_dp.
`timescale 1ns / 1ps

module three_level_stable_priority_queue_top
    import tspq_pkg::*;
#(
    parameter int CLASS_DEPTH = DEF_CLASS_DEPTH   // entries per class ring
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    // Input transactions
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [7:0] class_code, [23:8] cust_number, [39:24] duration
    input  logic [S_TDATA_W-1:0] s_tdata,
    // [0] mode (0 push, 1 pop)
    input  logic [S_TUSER_W-1:0] s_tuser,

    // Result transactions, one per input
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [7:0] out_code, [23:8] out_number, [39:24] out_duration, [40] now_empty,
    // [47:41] zero
    output logic [M_TDATA_W-1:0] m_tdata,
    // [1:0] status, [2] out_valid
    output logic [M_TUSER_W-1:0] m_tuser
);

    tspq_cmd_t cmd;

    // Controller: accepts a transaction only when no result is pending.
    tspq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // Datapath: class decode, priority pick, rings and result registers.
    tspq_dp #(
        .CLASS_DEPTH (CLASS_DEPTH)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for three_level_stable_priority_queue_top.
// Keeps its own copy of the three class rings and checks every result transaction.
// Depends on tspq_pkg and the RTL of the queue.
`timescale 1ns / 1ps

module tb_top;
    import tspq_pkg::*;

    localparam int QDEPTH      = DEF_CLASS_DEPTH;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_PRINTS  = 50;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                valid;
        logic [CODE_W-1:0]   code;
        logic [NUMBER_W-1:0] number;
        logic [DUR_W-1:0]    dur;
        logic                empty;
    } queue_result_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [S_TUSER_W-1:0] s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;

    // predicted queue contents
    logic [WORD_W-1:0] ring_mem [NUM_CLASSES][QDEPTH];
    int                ring_head [NUM_CLASSES];
    int                ring_tail [NUM_CLASSES];
    int                ring_fill [NUM_CLASSES];
    logic [CODE_W-1:0] class_codes [NUM_CLASSES] = '{CODE_P, CODE_G, CODE_S};

    queue_result_t pending_results [$];
    int            error_count = 0;
    int            cycle_count = 0;

    // traffic shaping knobs, set by the test tasks
    bit tx_gaps_on  = 0;
    bit rx_stall_on = 0;
    bit hold_req    = 0;
    int hold_cycles = 0;

    three_level_stable_priority_queue_top #(
        .CLASS_DEPTH(QDEPTH)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic int class_of(input logic [CODE_W-1:0] code);
        for (int i = 0; i < NUM_CLASSES; i++)
            if (code == class_codes[i]) return i;
        return -1;
    endfunction

    // Applies one transaction to the predicted queue and returns its result.
    function automatic queue_result_t predict_queue_op(input logic mode,
                                                       input logic [CODE_W-1:0] code,
                                                       input logic [NUMBER_W-1:0] num,
                                                       input logic [DUR_W-1:0] dur);
        queue_result_t     res;
        int                c;
        logic [WORD_W-1:0] word;
        res = '0;
        c = -1;
        if (mode == MODE_PUSH) begin
            c = class_of(code);
            if (c < 0) begin
                res.status = STAT_UNKNOWN;   // code wins over fullness
            end else if (ring_fill[c] >= QDEPTH) begin
                res.status = STAT_FULL;
            end else begin
                ring_mem[c][ring_tail[c]] = {num, dur};
                ring_tail[c] = (ring_tail[c] + 1) % QDEPTH;
                ring_fill[c]++;
            end
        end else begin
            for (int i = NUM_CLASSES - 1; i >= 0; i--)
                if (ring_fill[i] != 0) c = i;
            if (c < 0) begin
                res.status = STAT_EMPTY;
            end else begin
                word = ring_mem[c][ring_head[c]];
                ring_head[c] = (ring_head[c] + 1) % QDEPTH;
                ring_fill[c]--;
                res.valid  = 1'b1;
                res.code   = class_codes[c];
                res.number = word[WORD_W-1:DUR_W];
                res.dur    = word[DUR_W-1:0];
            end
        end
        res.empty = (ring_fill[0] + ring_fill[1] + ring_fill[2]) == 0;
        return res;
    endfunction

    task automatic flag_mismatch(input string what);
        error_count++;
        if (error_count <= MAX_PRINTS)
            $display("MISMATCH at %0t ns: %s", $time, what);
    endtask

    task automatic check_field(input string label, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            flag_mismatch($sformatf("%s got 0x%0h expected 0x%0h", label, got, want));
    endtask

    // Result checker: every accepted result transaction against the oldest prediction.
    always @(posedge aclk) begin : result_check
        queue_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                flag_mismatch("result transaction with nothing pending");
            end else begin
                want = pending_results.pop_front();
                check_field("status",   m_tuser[1:0],    want.status);
                check_field("valid",    m_tuser[2],      want.valid);
                check_field("code",     m_tdata[7:0],    want.code);
                check_field("number",   m_tdata[23:8],   want.number);
                check_field("duration", m_tdata[39:24],  want.dur);
                check_field("empty",    m_tdata[40],     want.empty);
                check_field("padding",  m_tdata[47:41],  16'h0);
            end
        end
    end

    // Result sink: random stalls, plus a long hold-off on request.
    initial begin : result_sink
        int k;
        m_tready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (hold_cycles) @(posedge aclk);
                hold_req = 0;
            end else if (rx_stall_on && $urandom_range(0, 99) < 30) begin
                m_tready <= 1'b0;
                k = idle_len();
                repeat ((k > 0) ? k : 1) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // Offers one transaction and records its prediction once it is taken.
    task automatic send_op(input logic mode, input logic [CODE_W-1:0] code,
                           input logic [NUMBER_W-1:0] num, input logic [DUR_W-1:0] dur);
        int gap;
        if (tx_gaps_on) begin
            gap = idle_len();
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {dur, num, code};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_results.push_back(predict_queue_op(mode, code, num, dur));
    endtask

    task automatic send_random(input int push_pct);
        logic              mode;
        logic [CODE_W-1:0] code;
        logic [NUMBER_W-1:0] num;
        logic [DUR_W-1:0]  dur;
        int                r;
        mode = ($urandom_range(0, 99) < push_pct) ? MODE_PUSH : MODE_POP;
        r = $urandom_range(0, 99);
        if (r < 28)      code = CODE_P;
        else if (r < 56) code = CODE_G;
        else if (r < 84) code = CODE_S;
        else             code = $urandom_range(0, 255);
        num = $urandom_range(0, 16'hFFFF);
        dur = $urandom_range(0, 16'hFFFF);
        send_op(mode, code, num, dur);
    endtask

    // Sender goes quiet until every predicted result has been taken.
    task automatic wait_all_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic test_directed_ops();
        tx_gaps_on  = 0;
        rx_stall_on = 0;
        send_op(MODE_POP,  8'hFF,  16'hFFFF, 16'hFFFF);   // pop on empty queue
        send_op(MODE_PUSH, CODE_P, 16'h0000, 16'h0000);
        send_op(MODE_PUSH, CODE_G, 16'hFFFF, 16'hFFFF);
        send_op(MODE_PUSH, CODE_S, 16'hA5A5, 16'h5A5A);
        send_op(MODE_PUSH, 8'h00,  16'h1234, 16'h5678);   // unknown codes
        send_op(MODE_PUSH, 8'hFF,  16'h4321, 16'h8765);
        send_op(MODE_POP,  8'h00,  16'h0000, 16'h0000);   // priority order P, G, S
        send_op(MODE_POP,  CODE_S, 16'h5555, 16'hAAAA);
        send_op(MODE_POP,  CODE_P, 16'hAAAA, 16'h5555);
        send_op(MODE_POP,  CODE_G, 16'h0000, 16'h0000);   // empty again
        wait_all_results();
    endtask

    task automatic test_class_full();
        for (int i = 0; i < QDEPTH; i++)
            send_op(MODE_PUSH, CODE_G, 16'(i * 16'h0101), 16'(16'hFFFF - i));
        send_op(MODE_PUSH, CODE_G, 16'hBEEF, 16'hCAFE);   // push into full class
        send_op(MODE_PUSH, 8'h67,  16'hBEEF, 16'hCAFE);   // unknown code beats full
        wait_all_results();
    endtask

    task automatic test_random_traffic();
        int push_mix [10] = '{60, 40, 95, 5, 70, 30, 95, 50, 20, 5};
        for (int p = 0; p < 10; p++) begin
            tx_gaps_on  = (p % 4) != 0;
            rx_stall_on = (p % 4) != 1 && p != 4;
            for (int i = 0; i < 52; i++)
                send_random(push_mix[p]);
            if (p % 3 == 2) wait_all_results();
        end
        wait_all_results();
    endtask

    // Sink holds off long while the source keeps offering, so the block backs up.
    task automatic test_backpressure();
        tx_gaps_on  = 0;
        rx_stall_on = 0;
        hold_cycles = 120;
        hold_req    = 1;
        for (int i = 0; i < 30; i++)
            send_random(60);
        while (hold_req) @(posedge aclk);
        wait_all_results();
    endtask

    initial begin : main
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        for (int i = 0; i < NUM_CLASSES; i++) begin
            ring_head[i] = 0;
            ring_tail[i] = 0;
            ring_fill[i] = 0;
        end
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_ops();
        test_class_full();
        test_random_traffic();
        test_backpressure();

        wait_all_results();
        repeat (10) @(posedge aclk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
